@@ rtl/u2a_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// u2a_pkg
// Shared types, constants and helpers for the binary to ASCII digit converter.
// ============================================================================
package u2a_pkg;

    // Widths of the number and of one digit.
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned CHAR_W    = 7;

    // Digit counts for each radix.
    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned HEX_DIGITS = 8;
    localparam int unsigned DIG_REG_W  = DEC_DIGITS * DIGIT_W;
    localparam int unsigned REM_W      = $clog2(DEC_DIGITS + 1);
    localparam int unsigned STEP_W     = $clog2(VALUE_W);

    // Radix select codes.
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;

    // ASCII anchors and the first letter digit.
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A     = 7'h41;
    localparam logic [DIGIT_W-1:0] ALPHA_START = 4'hA;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // Capture a new number.
        logic dabble;  // One shift-and-add-3 step of the decimal conversion.
        logic shift;   // Drop the top digit.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic top_zero;  // The top digit is zero.
        logic rem_one;   // Only one digit is left.
    } t_sts;

    // Map one digit value to its upper-case ASCII code.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < ALPHA_START) begin
            r = ASCII_ZERO + CHAR_W'(d);
        end else begin
            r = ASCII_A + CHAR_W'(d - ALPHA_START);
        end
        return r;
    endfunction

endpackage

@@ rtl/u2a_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// u2a_dp
// Datapath: binary shift register, digit register with shift-and-add-3
// correction, and the count of digits still to be sent.
// ============================================================================
module u2a_dp (
    input  logic                             i_clk,
    input  u2a_pkg::t_cmd                    i_cmd_ctl,
    input  logic                             i_radix,
    input  logic [u2a_pkg::VALUE_W-1:0]      i_value,
    output u2a_pkg::t_sts                    o_sts,
    output logic [u2a_pkg::CHAR_W-1:0]       o_character
);
    import u2a_pkg::*;

    logic [VALUE_W-1:0]   r_bin;
    logic [DIG_REG_W-1:0] r_dig;
    logic [REM_W-1:0]     r_rem;
    logic [DIG_REG_W-1:0] adj;

    // Add 3 to every decimal digit of 5 or more before the next shift.
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_dig[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[i*DIGIT_W +: DIGIT_W] = r_dig[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = r_dig[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Digit and binary registers. Hex digits are the value's nibbles, placed
    // so that the most significant nibble sits in the top digit slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_bin <= i_value;
            if (i_radix == RADIX_HEX) begin
                r_dig <= {i_value, {(DIG_REG_W - VALUE_W){1'b0}}};
                r_rem <= REM_W'(HEX_DIGITS);
            end else begin
                r_dig <= '0;
                r_rem <= REM_W'(DEC_DIGITS);
            end
        end else if (i_cmd_ctl.dabble) begin
            r_dig <= {adj[DIG_REG_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
        end else if (i_cmd_ctl.shift) begin
            r_dig <= {r_dig[DIG_REG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            r_rem <= r_rem - REM_W'(1);
        end
    end

    // Status and the current character.
    assign o_sts.top_zero = (r_dig[DIG_REG_W-1 -: DIGIT_W] == '0);
    assign o_sts.rem_one  = (r_rem == REM_W'(1));
    assign o_character    = digit_to_ascii(r_dig[DIG_REG_W-1 -: DIGIT_W]);

endmodule

@@ rtl/u2a_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// u2a_ctrl
// Controller: sequences load, decimal conversion, leading-zero skip and
// digit output, and owns both handshakes.
// ============================================================================
module u2a_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_radix,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  u2a_pkg::t_sts  i_sts,
    output u2a_pkg::t_cmd  o_cmd_ctl
);
    import u2a_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_in_ready, n_in_ready;
    logic                r_out_valid, n_out_valid;

    // Next state and datapath commands. A number is loaded only on an
    // accepted input beat, so not in the first cycle after reset.
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        o_cmd_ctl = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd_ctl.load = 1'b1;
                    n_step         = '0;
                    n_state        = (i_radix == RADIX_HEX) ? ST_SKIP : ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd_ctl.dabble = 1'b1;
                n_step           = r_step + STEP_W'(1);
                if (r_step == STEP_W'(VALUE_W - 1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_sts.top_zero && !i_sts.rem_one) begin
                    o_cmd_ctl.shift = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    if (i_sts.rem_one) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd_ctl.shift = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_in_ready  = (n_state == ST_IDLE);
        n_out_valid = (n_state == ST_EMIT);
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/uint32_to_ascii_dec_hex.sv @@
`timescale 1ns / 1ps
// ============================================================================
// uint32_to_ascii_dec_hex
// Unsigned 32-bit number to ASCII decimal or upper-case hexadecimal digits.
// ============================================================================
// One number is taken at a time. A decimal number goes through shift-and-add-3
// conversion, one value bit per cycle; a hexadecimal number needs none. Then
// leading zero digits are dropped one at a time (up to 9 in decimal, 7 in
// hex), then the digit beats follow, most significant first, with o_last on
// the final one. An output stall holds the current digit beat. A new number is
// accepted only after the last digit beat of the previous one has been taken.
module uint32_to_ascii_dec_hex (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic [u2a_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [u2a_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last
);
    import u2a_pkg::*;

    t_cmd cmd_ctl;
    t_sts sts;

    u2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_radix     (i_cmd),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd_ctl   (cmd_ctl)
    );

    u2a_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd_ctl   (cmd_ctl),
        .i_radix     (i_cmd),
        .i_value     (i_value),
        .o_sts       (sts),
        .o_character (o_character)
    );

    // The last beat of a number is the one with a single digit left.
    assign o_last = sts.rem_one;

endmodule

@@ rtl/u2a_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// u2a_checker
// Port-level checks on the converter, bound to the top level.
// ============================================================================
module u2a_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [6:0] o_character,
    input logic       o_last
);

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output beat changed while stalled");

    // Input is never taken while digits of a number are still pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while output beat pending");

    // A freshly accepted number does not show a digit in the next cycle.
    a_load_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("digit shown right after load");

    // Every character is a decimal digit or an upper-case hex letter.
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_character >= 7'h30 && o_character <= 7'h39) ||
                     (o_character >= 7'h41 && o_character <= 7'h46)))
        else $error("character outside digit range");

    // After the last beat is taken the run is over.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> !o_valid)
        else $error("beat after last");

endmodule

bind uint32_to_ascii_dec_hex u2a_checker u_u2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last)
);

@@ verif/uint32_to_ascii_dec_hex_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// uint32_to_ascii_dec_hex_tb
// Self-checking bench for the 32-bit binary to ASCII decimal/hex converter.
// A directed table covers zero, one, digit-count boundaries and the largest
// values in both radixes. A random phase follows, weighted toward short
// numbers and boundary values. Random gaps on the input side and random
// backpressure on the output side are applied, with one stretch at full rate.
// Every digit beat is compared against a queue filled from the table text or
// by a behavioral model of the conversion.
// ============================================================================
module uint32_to_ascii_dec_hex_tb;
    import u2a_pkg::*;

    localparam int unsigned CLK_HALF   = 2;
    localparam int unsigned RST_CYCLES = 6;
    localparam int unsigned RAND_ITEMS = 246;
    localparam int unsigned DIR_N      = 24;
    localparam int unsigned DRAIN_MAX  = 20000;
    localparam int unsigned TAIL_CYC   = 60;

    // One expected digit beat.
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_digit_beat;

    // One row of the directed table; an empty text means use the model.
    typedef struct {
        logic               radix;
        logic [VALUE_W-1:0] value;
        string              text;
    } t_dir_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_cmd   = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_character;
    logic               o_last;

    t_digit_beat digit_q[$];
    t_dir_row    dir_tbl[DIR_N];
    int unsigned err_cnt   = 0;
    int unsigned dec_cnt   = 0;
    int unsigned hex_cnt   = 0;
    int unsigned beat_cnt  = 0;
    bit          no_idle   = 1'b0;

    uint32_to_ascii_dec_hex dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // Free-running clock.
    always #(CLK_HALF) i_clk = ~i_clk;

    // Mostly zero, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Expected digits of one number, most significant first.
    function automatic void predict_digits(input logic radix, input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] base;
        logic [DIGIT_W-1:0] digs[DEC_DIGITS];
        int                 n;
        t_digit_beat        b;
        rest = value;
        base = (radix == RADIX_HEX) ? 32'd16 : 32'd10;
        n    = 0;
        do begin
            digs[n] = DIGIT_W'(rest % base);
            rest    = rest / base;
            n++;
        end while (rest != 0 && n < DEC_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            if (digs[k] < ALPHA_START) begin
                b.character = ASCII_ZERO + CHAR_W'(digs[k]);
            end else begin
                b.character = ASCII_A + CHAR_W'(digs[k] - ALPHA_START);
            end
            b.last = (k == 0);
            digit_q.push_back(b);
        end
    endfunction

    // Random number, weighted toward short values and digit-count boundaries.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] p;
        int                 e;
        case ($urandom_range(0, 4))
            0: begin
                return $urandom;
            end
            1: begin
                return $urandom >> $urandom_range(0, 31);
            end
            2: begin
                return $urandom_range(0, 20);
            end
            3: begin
                p = 32'd1;
                e = $urandom_range(0, 9);
                repeat (e) p = p * 32'd10;
                return p - 32'd1 + 32'($urandom_range(0, 2));
            end
            default: begin
                p = 32'd1 << (4 * $urandom_range(0, 7));
                return p - 32'($urandom_range(0, 1));
            end
        endcase
    endfunction

    // Present one number after a random gap and wait for the input beat.
    task automatic send_number(input logic radix, input logic [VALUE_W-1:0] value,
                               input string text);
        int          gap;
        t_digit_beat b;
        gap = no_idle ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) begin
                i_cmd   <= 1'($urandom);
                i_value <= $urandom;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_cmd   <= radix;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        if (text.len() > 0) begin
            for (int k = 0; k < text.len(); k++) begin
                b.character = CHAR_W'(text[k]);
                b.last      = (k == text.len() - 1);
                digit_q.push_back(b);
            end
        end else begin
            predict_digits(radix, value);
        end
        if (radix == RADIX_HEX) begin
            hex_cnt++;
        end else begin
            dec_cnt++;
        end
    endtask

    // Output backpressure: bursts of ready and stall of random length.
    initial begin
        int burst;
        bit stall;
        burst = 0;
        stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst == 0) begin
                stall = ($urandom_range(0, 3) == 0);
                burst = stall ? 1 + pick_gap() : $urandom_range(1, 16);
            end
            i_ready <= no_idle || !stall;
            burst--;
        end
    end

    // Compare every output beat with the oldest expected digit.
    always @(posedge i_clk) begin
        t_digit_beat exp_b;
        if (i_rst_n && o_valid && i_ready) begin
            beat_cnt++;
            if (digit_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected beat char=0x%02h last=%0b",
                         $time, o_character, o_last);
            end else begin
                exp_b = digit_q.pop_front();
                if (o_character !== exp_b.character) begin
                    err_cnt++;
                    $display("%0t: character expected 0x%02h actual 0x%02h",
                             $time, exp_b.character, o_character);
                end
                if (o_last !== exp_b.last) begin
                    err_cnt++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, exp_b.last, o_last);
                end
            end
        end
    end

    // Main sequence.
    initial begin
        int unsigned wait_cyc;
        dir_tbl = '{
            '{RADIX_DEC, 32'd0,          "0"},
            '{RADIX_HEX, 32'd0,          "0"},
            '{RADIX_DEC, 32'd1,          "1"},
            '{RADIX_HEX, 32'd1,          "1"},
            '{RADIX_DEC, 32'd9,          "9"},
            '{RADIX_DEC, 32'd10,         "10"},
            '{RADIX_HEX, 32'h9,          "9"},
            '{RADIX_HEX, 32'hA,          "A"},
            '{RADIX_HEX, 32'hF,          "F"},
            '{RADIX_HEX, 32'h10,         "10"},
            '{RADIX_DEC, 32'd99,         ""},
            '{RADIX_DEC, 32'd100,        ""},
            '{RADIX_DEC, 32'd999999999,  "999999999"},
            '{RADIX_DEC, 32'd1000000000, "1000000000"},
            '{RADIX_DEC, 32'hFFFFFFFF,   "4294967295"},
            '{RADIX_HEX, 32'hFFFFFFFF,   "FFFFFFFF"},
            '{RADIX_DEC, 32'h80000000,   "2147483648"},
            '{RADIX_HEX, 32'h80000000,   "80000000"},
            '{RADIX_HEX, 32'h0FFFFFFF,   "FFFFFFF"},
            '{RADIX_HEX, 32'h10000000,   "10000000"},
            '{RADIX_HEX, 32'h12345678,   ""},
            '{RADIX_HEX, 32'hABCDEF09,   "ABCDEF09"},
            '{RADIX_DEC, 32'h55555555,   ""},
            '{RADIX_HEX, 32'hAAAAAAAA,   "AAAAAAAA"}
        };

        // Hold reset, then release on a falling edge.
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            send_number(dir_tbl[r].radix, dir_tbl[r].value, dir_tbl[r].text);
        end

        // Random phase, with one stretch at full rate on both sides.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            no_idle = (n >= 100 && n < 160);
            send_number(1'($urandom), pick_value(), "");
        end
        no_idle = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain the expected digits, then watch for stray beats.
        wait_cyc = 0;
        while (digit_q.size() != 0 && wait_cyc < DRAIN_MAX) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        if (digit_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d expected digits never arrived", $time, digit_q.size());
        end
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("Converted %0d decimal and %0d hex numbers, %0d digit beats checked.",
                 dec_cnt, hex_cnt, beat_cnt);
        if (err_cnt == 0) begin
            $display("[uint32_to_ascii_dec_hex] OK");
        end else begin
            $display("%0d mismatches found.", err_cnt);
            $display("[uint32_to_ascii_dec_hex] ERROR");
        end
        $finish;
    end

    // Watchdog in case the handshake hangs.
    initial begin
        #5ms;
        $display("%0t: timeout", $time);
        $display("[uint32_to_ascii_dec_hex] ERROR");
        $finish;
    end

endmodule
